/* rtl/salc_pkg.sv */
package salc_pkg;

    // Cache geometry (powers of two)
    localparam int WAYS        = 8;
    localparam int SETS        = 16;
    localparam int BLOCK_BYTES = 8;

    localparam int ADDR_W   = 32;
    localparam int CNT_W    = 32;
    localparam int OFF_BITS = $clog2(BLOCK_BYTES);
    localparam int SET_BITS = $clog2(SETS);
    localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
    localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W   = WAY_W;
    localparam int OLD_W    = RANK_W + 1;
    localparam int TAG_W    = ADDR_W - OFF_BITS - SET_BITS;

    // Result beat: hit, writeback, way_used, five counters, zero padded to bytes
    localparam int OUT_RAW_W = 2 + WAY_W + 5 * CNT_W;
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;
    localparam int OUT_PAD_W = OUT_W - OUT_RAW_W;

    // Per-way replacement state, one field of a state row
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic              dirty;
        logic              valid;
    } t_line_st;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_status;

endpackage

/* rtl/salc_ctrl.sv */
module salc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  salc_pkg::t_status i_status,
    output salc_pkg::t_cmd    o_cmd
);
    import salc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_LOOKUP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // Handshake and commands
    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.commit = (r_state == S_LOOKUP) && !i_status.out_busy;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                if (!i_status.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/salc_datapath.sv */
module salc_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  salc_pkg::t_cmd                      i_cmd,
    output salc_pkg::t_status                   o_status,
    input  logic                                i_kind,
    input  logic [salc_pkg::ADDR_W-1:0]         i_addr,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [salc_pkg::OUT_W-1:0]          o_out_data
);
    import salc_pkg::*;

    // Set rows: tags and replacement state, one row per set
    logic [WAYS-1:0][TAG_W-1:0] r_tag_mem [SETS];
    t_line_st [WAYS-1:0]        r_st_mem  [SETS];
    logic [SETS-1:0]            r_row_ok;

    logic [ADDR_W-1:0]          w_block;
    logic [SET_W-1:0]           w_set;
    logic [TAG_W-1:0]           w_tag;

    logic                       r_kind;
    logic [SET_W-1:0]           r_set;
    logic [TAG_W-1:0]           r_tag;
    logic [WAYS-1:0][TAG_W-1:0] r_rd_tag;
    t_line_st [WAYS-1:0]        r_rd_st_raw;
    logic                       r_rd_ok;
    t_line_st [WAYS-1:0]        w_rd_st;

    logic                       w_hit;
    logic                       w_found;
    logic [WAY_W-1:0]           w_hway;
    logic [WAY_W-1:0]           w_fway;
    logic [WAY_W-1:0]           w_lway;
    logic [WAY_W-1:0]           w_way;
    logic [OLD_W-1:0]           w_old;
    logic                       w_wb;
    t_line_st [WAYS-1:0]        w_new_st;
    logic [WAYS-1:0][TAG_W-1:0] w_new_tag;

    logic [CNT_W-1:0]           r_rd_cnt, n_rd_cnt;
    logic [CNT_W-1:0]           r_wr_cnt, n_wr_cnt;
    logic [CNT_W-1:0]           r_wb_cnt, n_wb_cnt;
    logic [CNT_W-1:0]           r_rh_cnt, n_rh_cnt;
    logic [CNT_W-1:0]           r_wh_cnt, n_wh_cnt;

    logic                       r_out_valid;
    logic [OUT_W-1:0]           r_out_data;

    // Address split
    assign w_block = i_addr >> OFF_BITS;
    assign w_set   = SET_W'(w_block % ADDR_W'(SETS));
    assign w_tag   = TAG_W'(w_block / ADDR_W'(SETS));

    // Capture the beat and read its set row
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind      <= i_kind;
            r_set       <= w_set;
            r_tag       <= w_tag;
            r_rd_tag    <= r_tag_mem[w_set];
            r_rd_st_raw <= r_st_mem[w_set];
            r_rd_ok     <= r_row_ok[w_set];
        end
    end

    // A row never written reads as all invalid
    assign w_rd_st = r_rd_ok ? r_rd_st_raw : '0;

    // Hit, first invalid way and LRU victim; lowest way wins each search
    always_comb begin
        w_hit   = 1'b0;
        w_found = 1'b0;
        w_hway  = '0;
        w_fway  = '0;
        w_lway  = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (w_rd_st[i].valid && (r_rd_tag[i] == r_tag)) begin
                w_hit  = 1'b1;
                w_hway = WAY_W'(i);
            end
            if (!w_rd_st[i].valid) begin
                w_found = 1'b1;
                w_fway  = WAY_W'(i);
            end
            if (w_rd_st[i].rank == RANK_W'(WAYS - 1)) begin
                w_lway = WAY_W'(i);
            end
        end
    end

    // Way chosen and the rank it leaves
    always_comb begin
        priority if (w_hit) begin
            w_way = w_hway;
            w_old = {1'b0, w_rd_st[w_hway].rank};
            w_wb  = 1'b0;
        end else if (w_found) begin
            w_way = w_fway;
            w_old = OLD_W'(WAYS);
            w_wb  = 1'b0;
        end else begin
            w_way = w_lway;
            w_old = {1'b0, w_rd_st[w_lway].rank};
            w_wb  = w_rd_st[w_lway].dirty;
        end
    end

    // Updated row: promote chosen way, age the more recent valid ways
    always_comb begin
        w_new_st  = w_rd_st;
        w_new_tag = r_rd_tag;
        for (int i = 0; i < WAYS; i++) begin
            if (WAY_W'(i) == w_way) begin
                w_new_st[i].rank  = '0;
                w_new_st[i].valid = 1'b1;
                if (w_hit) begin
                    w_new_st[i].dirty = w_rd_st[i].dirty | r_kind;
                end else begin
                    w_new_st[i].dirty = r_kind;
                    w_new_tag[i]      = r_tag;
                end
            end else if (w_rd_st[i].valid && ({1'b0, w_rd_st[i].rank} < w_old)) begin
                w_new_st[i].rank = w_rd_st[i].rank + RANK_W'(1);
            end
        end
    end

    // Running counters after this access
    always_comb begin
        n_rd_cnt = r_rd_cnt + CNT_W'(!r_kind);
        n_wr_cnt = r_wr_cnt + CNT_W'(r_kind);
        n_wb_cnt = r_wb_cnt + CNT_W'(w_wb);
        n_rh_cnt = r_rh_cnt + CNT_W'(w_hit && !r_kind);
        n_wh_cnt = r_wh_cnt + CNT_W'(w_hit && r_kind);
    end

    // Row write-back at commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_tag_mem[r_set] <= w_new_tag;
            r_st_mem[r_set]  <= w_new_st;
        end
    end

    // Row valid bits and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
            r_rd_cnt <= '0;
            r_wr_cnt <= '0;
            r_wb_cnt <= '0;
            r_rh_cnt <= '0;
            r_wh_cnt <= '0;
        end else if (i_cmd.commit) begin
            r_row_ok[r_set] <= 1'b1;
            r_rd_cnt        <= n_rd_cnt;
            r_wr_cnt        <= n_wr_cnt;
            r_wb_cnt        <= n_wb_cnt;
            r_rh_cnt        <= n_rh_cnt;
            r_wh_cnt        <= n_wh_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= {{OUT_PAD_W{1'b0}}, n_wh_cnt, n_rh_cnt, n_wb_cnt,
                           n_wr_cnt, n_rd_cnt, w_way, w_wb, w_hit};
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_status.out_busy = r_out_valid && !i_out_ready;

`ifndef SYNTH
    // A commit always presents a result beat
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("commit without result beat");

    // A hit never reports a write-back
    a_hit_no_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_data[0] && r_out_data[1]))
        else $error("write-back flagged on a hit");

    // The committed set row is marked as written
    a_row_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_row_ok[r_set])
        else $error("committed row not marked");

    // Write-back counter steps exactly with a dirty eviction
    a_wb_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> (r_wb_cnt == $past(r_wb_cnt) + CNT_W'($past(w_wb))))
        else $error("write-back counter mismatch");

    // No beat is taken while a lookup is being committed
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.accept && i_cmd.commit))
        else $error("accept during commit");
`endif

endmodule

/* rtl/set_assoc_lru_writeback_cache.sv */
// Channel   Dir  Handshake                       Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: address; tuser: kind
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: hit, writeback, way_used, totals
//
// The accept cycle reads the set's tag and state rows; the lookup state, once the
// output is free, updates and writes them back and loads the result.
// The single-port set rows take one read and one write per access.
// Reset clears the row valid bits, counters and control at once; no clearing pass.
// A stalled result holds the lookup stage; a new beat is taken while a result waits.
module set_assoc_lru_writeback_cache (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [salc_pkg::ADDR_W-1:0] i_s_axis_tdata,  // [31:0] address
    input  logic                        i_s_axis_tuser,  // [0] kind
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // [0] hit, [1] writeback, [4:2] way_used, [36:5] read_total,
    // [68:37] write_total, [100:69] writeback_total, [132:101] read_hit_total,
    // [164:133] write_hit_total, rest zero
    output logic [salc_pkg::OUT_W-1:0]  o_m_axis_tdata
);
    import salc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer
    salc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Set rows, lookup and counters
    salc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_kind      (i_s_axis_tuser),
        .i_addr      (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

/* dv/tb_set_assoc_lru_writeback_cache.sv */
`timescale 1ns / 1ps

module tb_set_assoc_lru_writeback_cache;

    import salc_pkg::*;

    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;
    localparam int   LINES      = WAYS * SETS;
    localparam int   CYCLE_LIMIT = 400000;
    localparam int   HOLD_CYCLES = 300;
    localparam int   DRAIN_CYCLES = 20;
    localparam int   REPORT_MAX  = 10;

    // Result beat as packed on tdata, lowest field last
    typedef struct packed {
        logic [OUT_PAD_W-1:0] pad;
        logic [CNT_W-1:0]     wr_hit_cnt;
        logic [CNT_W-1:0]     read_hits;
        logic [CNT_W-1:0]     writebacks;
        logic [CNT_W-1:0]     writes;
        logic [CNT_W-1:0]     reads;
        logic [WAY_W-1:0]     way;
        logic                 writeback;
        logic                 hit;
    } t_cache_outcome;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [ADDR_W-1:0]   i_s_axis_tdata;   // [31:0] address
    logic                i_s_axis_tuser;   // [0] kind
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    // [0] hit, [1] writeback, [4:2] way_used, then five 32-bit totals, rest zero
    logic [OUT_W-1:0]    o_m_axis_tdata;

    set_assoc_lru_writeback_cache u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // Shadow copy of the tag store and counters
    logic              line_valid [LINES];
    logic              line_dirty [LINES];
    logic [TAG_W-1:0]  line_tag   [LINES];
    logic [RANK_W-1:0] line_rank  [LINES];
    logic [CNT_W-1:0]  reads_seen, writes_seen, writebacks_seen;
    logic [CNT_W-1:0]  read_hits_seen, wr_hit_cnt_seen;

    t_cache_outcome pending_outcomes [$];

    int  send_idle_pct;
    int  stall_pct;
    bit  hold_off;
    int  cycle_count;
    int  mismatch_count;
    int  beats_checked;
    int  hits_checked;
    int  evictions_checked;
    int  stray_count;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Move a way to the front of its set; younger valid ways age by one
    function automatic void promote_way(input int base, input int way_sel, input int old_rank);
        for (int i = 0; i < WAYS; i++) begin
            if (i != way_sel && line_valid[base + i] && int'(line_rank[base + i]) < old_rank)
                line_rank[base + i] = line_rank[base + i] + 1'b1;
        end
        line_rank[base + way_sel] = '0;
    endfunction

    // Work out the result of one access and queue it
    function automatic void predict_access(input logic kind, input logic [ADDR_W-1:0] addr);
        int             set_idx;
        int             base;
        int             way_sel;
        logic [TAG_W-1:0] tag;
        logic           hit;
        logic           found;
        logic           wb;
        t_cache_outcome outcome;

        set_idx = int'(addr[OFF_BITS +: SET_BITS]);
        tag     = addr[ADDR_W-1 -: TAG_W];
        base    = set_idx * WAYS;
        way_sel = 0;
        hit     = 1'b0;
        found   = 1'b0;
        wb      = 1'b0;

        if (kind == KIND_WRITE)
            writes_seen++;
        else
            reads_seen++;

        for (int i = 0; i < WAYS && !hit; i++) begin
            if (line_valid[base + i] && line_tag[base + i] == tag) begin
                hit = 1'b1;
                way_sel = i;
            end
        end

        if (hit) begin
            promote_way(base, way_sel, int'(line_rank[base + way_sel]));
            if (kind == KIND_WRITE) begin
                line_dirty[base + way_sel] = 1'b1;
                wr_hit_cnt_seen++;
            end else begin
                read_hits_seen++;
            end
        end else begin
            for (int i = 0; i < WAYS && !found; i++) begin
                if (!line_valid[base + i]) begin
                    found = 1'b1;
                    way_sel = i;
                end
            end
            if (found) begin
                line_valid[base + way_sel] = 1'b1;
                promote_way(base, way_sel, WAYS);
            end else begin
                // victim is the oldest way, way 0 if none holds that rank
                for (int i = WAYS - 1; i >= 0; i--) begin
                    if (int'(line_rank[base + i]) == WAYS - 1)
                        way_sel = i;
                end
                if (line_dirty[base + way_sel]) begin
                    wb = 1'b1;
                    writebacks_seen++;
                end
                promote_way(base, way_sel, int'(line_rank[base + way_sel]));
            end
            line_tag[base + way_sel]   = tag;
            line_dirty[base + way_sel] = (kind == KIND_WRITE);
        end

        outcome            = '0;
        outcome.hit        = hit;
        outcome.writeback  = wb;
        outcome.way        = way_sel[WAY_W-1:0];
        outcome.reads      = reads_seen;
        outcome.writes     = writes_seen;
        outcome.writebacks = writebacks_seen;
        outcome.read_hits  = read_hits_seen;
        outcome.wr_hit_cnt = wr_hit_cnt_seen;
        pending_outcomes.push_back(outcome);
    endfunction

    function automatic logic [ADDR_W-1:0] block_address(input logic [TAG_W-1:0] tag,
                                                         input int set_idx, input int offset);
        return (ADDR_W'(tag) << (OFF_BITS + SET_BITS)) | (ADDR_W'(set_idx) << OFF_BITS)
               | ADDR_W'(offset);
    endfunction

    // One access beat on the input side, with random idle cycles ahead of it
    task automatic send_access(input logic kind, input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            i_s_axis_tdata  = $urandom;
            i_s_axis_tuser  = $urandom_range(1);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = addr;
        i_s_axis_tuser  = kind;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        predict_access(kind, addr);
    endtask

    task automatic release_input;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    // Mostly a small tag pool per phase so sets fill, hit and evict; some wild addresses
    task automatic send_random_accesses(input int count);
        logic [TAG_W-1:0] tag_pool [16];
        int               pool_size;
        logic [ADDR_W-1:0] addr;

        pool_size = $urandom_range(9, 16);
        for (int i = 0; i < 16; i++)
            tag_pool[i] = TAG_W'($urandom);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 15)
                addr = $urandom;
            else
                addr = block_address(tag_pool[$urandom_range(pool_size - 1)],
                                     $urandom_range(SETS - 1), $urandom_range(BLOCK_BYTES - 1));
            send_access($urandom_range(1) ? KIND_WRITE : KIND_READ, addr);
        end
        release_input();
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct = sender_pct;
        stall_pct     = receiver_pct;
    endtask

    // Address extremes, filling one set, hits of both kinds, clean and dirty evictions
    task automatic test_directed;
        set_idling(0, 0);
        send_access(KIND_READ, '0);
        send_access(KIND_READ, ADDR_W'(BLOCK_BYTES - 1));
        send_access(KIND_WRITE, '1);
        send_access(KIND_READ, block_address('1, SETS - 1, 0));
        for (int t = 1; t <= WAYS; t++)
            send_access((t % 2) ? KIND_WRITE : KIND_READ, block_address(TAG_W'(t), 5, t % BLOCK_BYTES));
        send_access(KIND_READ, block_address(TAG_W'(1), 5, 0));
        send_access(KIND_WRITE, block_address(TAG_W'(2), 5, 3));
        for (int t = WAYS + 1; t <= WAYS + 6; t++)
            send_access(KIND_READ, block_address(TAG_W'(t), 5, 0));
        send_access(KIND_WRITE, block_address(TAG_W'(WAYS + 1), 5, BLOCK_BYTES - 1));
        send_access(KIND_READ, block_address(TAG_W'(1), 5, 0));
        release_input();
    endtask

    task automatic test_streaming;
        set_idling(0, 0);
        send_random_accesses(400);
    endtask

    task automatic test_sender_gaps;
        set_idling(59, 0);
        send_random_accesses(300);
    endtask

    task automatic test_receiver_stalls;
        set_idling(0, 59);
        send_random_accesses(300);
    endtask

    task automatic test_both_idle;
        set_idling(31, 31);
        send_random_accesses(300);
    endtask

    // Output held off long enough for the block to back up into its input
    task automatic test_output_hold;
        set_idling(0, 20);
        fork
            begin
                hold_off = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
            send_random_accesses(250);
        join
    endtask

    // Receiver ready, dropped at random or for the hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n)
            i_m_axis_tready = 1'b0;
        else
            i_m_axis_tready = !hold_off && ($urandom_range(99) >= stall_pct);
    end

    task automatic check_field(input string field, input logic [CNT_W-1:0] expected,
                               input logic [CNT_W-1:0] actual);
        if (expected !== actual) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
                $display("mismatch on beat %0d, %s: expected 0x%0h, got 0x%0h",
                         beats_checked, field, expected, actual);
        end
    endtask

    // Compare every output beat with the oldest queued outcome
    always @(posedge i_clk) begin
        t_cache_outcome expected;
        t_cache_outcome actual;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            actual = t_cache_outcome'(o_m_axis_tdata);
            if (pending_outcomes.size() == 0) begin
                stray_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("result beat with nothing outstanding: 0x%0h", o_m_axis_tdata);
            end else begin
                expected = pending_outcomes.pop_front();
                check_field("hit", expected.hit, actual.hit);
                check_field("writeback", expected.writeback, actual.writeback);
                check_field("way_used", expected.way, actual.way);
                check_field("read_total", expected.reads, actual.reads);
                check_field("write_total", expected.writes, actual.writes);
                check_field("writeback_total", expected.writebacks, actual.writebacks);
                check_field("read_hit_total", expected.read_hits, actual.read_hits);
                check_field("write_hit_total", expected.wr_hit_cnt, actual.wr_hit_cnt);
                check_field("padding", expected.pad, actual.pad);
                hits_checked      += expected.hit;
                evictions_checked += expected.writeback;
            end
            beats_checked++;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_outcomes.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = KIND_READ;
        i_m_axis_tready = 1'b0;
        hold_off        = 1'b0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        cycle_count     = 0;
        mismatch_count  = 0;
        beats_checked   = 0;
        hits_checked    = 0;
        evictions_checked = 0;
        stray_count     = 0;
        reads_seen      = '0;
        writes_seen     = '0;
        writebacks_seen = '0;
        read_hits_seen  = '0;
        wr_hit_cnt_seen = '0;
        for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_tag[i]   = '0;
            line_rank[i]  = '0;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        test_output_hold();

        set_idling(0, 0);
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d result beats: %0d hits, %0d dirty evictions, %0d mismatches.",
                 beats_checked, hits_checked, evictions_checked, mismatch_count);
        $display("Phases: directed, streaming, sender gaps, receiver stalls, both, long hold-off.");
        if (mismatch_count == 0 && stray_count == 0 && pending_outcomes.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
